[hdl/assert_macros.svh]
// Assertion macros used by timer_min_heap_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion on clk_i, held off during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

[hdl/tmh_pkg.sv]
//------------------------------------------------------------------------------
// tmh_pkg
// Shared constants for the timer min-heap.
//------------------------------------------------------------------------------
`default_nettype none
package tmh_pkg;
  localparam int unsigned DefDepth    = 32;
  localparam int unsigned DefTimeBits = 48;
  localparam int unsigned DefIdBits   = 16;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned KindW   = 2;
  localparam int unsigned OutIdW  = 16;
  localparam int unsigned InTimeW = 48;
  localparam int unsigned WaitW   = 49;
  localparam int unsigned CountW  = 6;

  localparam logic [CmdW-1:0] CmdAdd     = 2'd0;
  localparam logic [CmdW-1:0] CmdService = 2'd1;
  localparam logic [CmdW-1:0] CmdQuery   = 2'd2;
  localparam logic [CmdW-1:0] CmdUnused  = 2'd3;

  localparam logic [KindW-1:0] KindAdded  = 2'd0;
  localparam logic [KindW-1:0] KindFired  = 2'd1;
  localparam logic [KindW-1:0] KindWait   = 2'd2;
  localparam logic [KindW-1:0] KindReject = 2'd3;
endpackage
`default_nettype wire

[hdl/tmh_cmd_if.sv]
//------------------------------------------------------------------------------
// tmh_cmd_if / tmh_res_if
// Valid/ready channels for command items and result items.
//------------------------------------------------------------------------------
`default_nettype none
interface tmh_cmd_if import tmh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    cmd;
  logic [InTimeW-1:0] expire_time;
  logic [InTimeW-1:0] now_time;
  modport source (output valid, cmd, expire_time, now_time, input ready);
  modport sink   (input valid, cmd, expire_time, now_time, output ready);
endinterface

interface tmh_res_if import tmh_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KindW-1:0]        kind;
  logic [OutIdW-1:0]       timer_id;
  logic signed [WaitW-1:0] wait_ms;
  logic [CountW-1:0]       pending_count;
  logic                    last;
  modport source (output valid, kind, timer_id, wait_ms, pending_count, last,
                  input ready);
  modport sink   (input valid, kind, timer_id, wait_ms, pending_count, last,
                  output ready);
endinterface
`default_nettype wire

[hdl/tmh_heap_ram.sv]
//------------------------------------------------------------------------------
// tmh_heap_ram
// Heap entry store: one write port, one read port, registered read data.
//------------------------------------------------------------------------------
`default_nettype none
module tmh_heap_ram import tmh_pkg::*; #(
  parameter int unsigned Depth = DefDepth,
  parameter int unsigned Width = DefTimeBits + DefIdBits,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [Width-1:0]   rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

[hdl/timer_min_heap_core.sv]
//------------------------------------------------------------------------------
// timer_min_heap_core
// Binary min-heap of pending timers with add, service and query commands.
//------------------------------------------------------------------------------
// Usage:
//   cmd_i carries command items (cmd, expire_time, now_time); res_o carries
//   result items (kind, timer_id, wait_ms, pending_count, last). An add gives
//   one result (added or rejected), a query one wait report, a service one
//   fired item per due timer (possibly none), and the unused code none.
//   The heap lives in one RAM of DEPTH entries with registered read data;
//   the root is mirrored in a register so query and due checks need no read.
//   Working steps: an add is written at the tail and climbs, moving each
//   larger parent down one level, until it stops or reaches the root.
//   A service pops the due root, moves the last entry to the root and
//   sinks it past the smaller child (left on a tie) until it stops, then
//   reports the fired timer. A lone entry fires without a sift.
//   One command is worked at a time: cmd ready is high only when idle with
//   the result register empty, so the next item is taken the cycle after
//   the last result of the previous one leaves.
//   A result waits in the output register while res ready is low; further
//   pops hold until it is taken.
//   Reset empties the heap and zeroes the id counter at once; the RAM is not
//   cleared since only entries below the count are ever read.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module timer_min_heap_core import tmh_pkg::*; #(
  parameter int unsigned DEPTH     = DefDepth,
  parameter int unsigned TIME_BITS = DefTimeBits,
  parameter int unsigned ID_BITS   = DefIdBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tmh_cmd_if.sink   cmd_i,
  tmh_res_if.source res_o
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = AW + 2;
  localparam int unsigned EW = TIME_BITS + ID_BITS;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SUpRd    = 4'd1;
  localparam logic [3:0] SUpCmp   = 4'd2;
  localparam logic [3:0] SPop     = 4'd3;
  localparam logic [3:0] SLastGet = 4'd4;
  localparam logic [3:0] SDnRd    = 4'd5;
  localparam logic [3:0] SLGet    = 4'd6;
  localparam logic [3:0] SRGet    = 4'd7;
  localparam logic [3:0] SDnCmp   = 4'd8;
  localparam logic [3:0] SFire    = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [ID_BITS-1:0] nid_q, nid_d;
  logic [EW-1:0] root_q, root_d;      // copy of entry 0
  logic [EW-1:0] cur_q, cur_d;        // entry being sifted
  logic [EW-1:0] lch_q, lch_d;        // smaller child seen so far
  logic          rsel_q, rsel_d;      // smaller child is the right one
  logic [AW-1:0] pos_q, pos_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [ID_BITS-1:0] fid_q, fid_d;
  logic        rv_q, rv_d;
  logic [KindW-1:0] rk_q, rk_d;
  logic [OutIdW-1:0] rid_q, rid_d;
  logic [WaitW-1:0] rw_q, rw_d;
  logic [CountW-1:0] rc_q, rc_d;
  logic        rl_q, rl_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  tmh_heap_ram #(.Depth(DEPTH), .Width(EW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [TIME_BITS-1:0] tkey(input logic [EW-1:0] e);
    return e[EW-1:ID_BITS];
  endfunction

  logic take_cmd, res_free;
  logic [XW-1:0] l_idx, r_idx, cnt_x;
  logic [AW-1:0] parent;
  logic root_due;

  assign res_free = !rv_q || res_o.ready;
  assign cmd_i.ready = (state_q == SIdle) && !rv_q;
  assign take_cmd = cmd_i.valid && cmd_i.ready;
  assign l_idx = {1'b0, pos_q, 1'b1};
  assign r_idx = l_idx + XW'(1);
  assign cnt_x = XW'(count_q);
  assign parent = (pos_q - AW'(1)) >> 1;
  assign root_due = (count_q != '0) && (tkey(root_q) <= now_q);

  always_comb begin
    state_d = state_q; count_d = count_q; nid_d = nid_q; root_d = root_q;
    cur_d = cur_q; lch_d = lch_q; rsel_d = rsel_q; pos_d = pos_q;
    now_d = now_q; fid_d = fid_q;
    rv_d = rv_q && !res_o.ready;
    rk_d = rk_q; rid_d = rid_q; rw_d = rw_q; rc_d = rc_q; rl_d = rl_q;
    we = 1'b0; waddr = pos_q; wdata = cur_q; raddr = parent;
    unique case (state_q)
      SIdle: begin
        if (take_cmd) begin
          now_d = cmd_i.now_time[TIME_BITS-1:0];
          unique case (cmd_i.cmd)
            CmdAdd: begin
              if (count_q >= DepthC) begin
                rv_d = 1'b1; rk_d = KindReject; rid_d = '0; rw_d = '0;
                rc_d = CountW'(count_q); rl_d = 1'b1;
              end else begin
                // Append at the tail, then climb.
                cur_d = {cmd_i.expire_time[TIME_BITS-1:0], nid_q};
                pos_d = AW'(count_q);
                rid_d = OutIdW'(nid_q);
                nid_d = nid_q + ID_BITS'(1);
                count_d = count_q + CW'(1);
                state_d = SUpRd;
              end
            end
            CmdService: state_d = SPop;
            CmdQuery: begin
              rv_d = 1'b1; rk_d = KindWait; rid_d = '0;
              rc_d = CountW'(count_q); rl_d = 1'b1;
              if (count_q == '0) rw_d = '1;
              else if (tkey(root_q) > cmd_i.now_time[TIME_BITS-1:0])
                rw_d = WaitW'(tkey(root_q) - cmd_i.now_time[TIME_BITS-1:0]);
              else rw_d = '0;
            end
            CmdUnused: ;
          endcase
        end
      end
      SUpRd: begin
        // Root reached: place entry and report.
        if (pos_q == '0) begin
          we = 1'b1; root_d = cur_q;
          rv_d = 1'b1; rk_d = KindAdded; rw_d = '0;
          rc_d = CountW'(count_q); rl_d = 1'b1;
          state_d = SIdle;
        end else begin
          state_d = SUpCmp;
        end
      end
      SUpCmp: begin
        if (tkey(cur_q) < tkey(rdata)) begin
          // Move the parent down one level and keep climbing.
          we = 1'b1; wdata = rdata; pos_d = parent; state_d = SUpRd;
        end else begin
          we = 1'b1;
          rv_d = 1'b1; rk_d = KindAdded; rw_d = '0;
          rc_d = CountW'(count_q); rl_d = 1'b1;
          state_d = SIdle;
        end
      end
      SPop: begin
        if (!res_free) begin
          state_d = SPop;
        end else if (!root_due) begin
          state_d = SIdle;
        end else begin
          fid_d = root_q[ID_BITS-1:0];
          count_d = count_q - CW'(1);
          if (count_q == CW'(1)) begin
            rv_d = 1'b1; rk_d = KindFired; rid_d = OutIdW'(root_q[ID_BITS-1:0]);
            rw_d = '0; rc_d = '0; rl_d = 1'b1;
            state_d = SIdle;
          end else begin
            // Fetch the last entry; it restarts at the root.
            raddr = AW'(count_q - CW'(1));
            state_d = SLastGet;
          end
        end
      end
      SLastGet: begin
        cur_d = rdata; pos_d = '0; state_d = SDnRd;
      end
      SDnRd: begin
        if (l_idx >= cnt_x) begin
          we = 1'b1;
          if (pos_q == '0) root_d = cur_q;
          state_d = SFire;
        end else begin
          raddr = AW'(l_idx); state_d = SLGet;
        end
      end
      SLGet: begin
        lch_d = rdata; rsel_d = 1'b0;
        if (r_idx < cnt_x) begin
          raddr = AW'(r_idx); state_d = SRGet;
        end else begin
          state_d = SDnCmp;
        end
      end
      SRGet: begin
        // Pick the smaller child, left on a tie.
        if (tkey(rdata) < tkey(lch_q)) begin
          lch_d = rdata; rsel_d = 1'b1;
        end
        state_d = SDnCmp;
      end
      SDnCmp: begin
        if (tkey(lch_q) < tkey(cur_q)) begin
          we = 1'b1; wdata = lch_q;
          if (pos_q == '0) root_d = lch_q;
          pos_d = rsel_q ? AW'(r_idx) : AW'(l_idx);
          state_d = SDnRd;
        end else begin
          we = 1'b1;
          if (pos_q == '0) root_d = cur_q;
          state_d = SFire;
        end
      end
      SFire: begin
        // Sift done: report this fired timer, go on while the root is due.
        rv_d = 1'b1; rk_d = KindFired; rid_d = OutIdW'(fid_q); rw_d = '0;
        rc_d = CountW'(count_q);
        rl_d = !root_due;
        state_d = root_due ? SPop : SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; count_q <= '0; nid_q <= '0; rv_q <= 1'b0; rsel_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; nid_q <= nid_d; rv_q <= rv_d;
      rsel_q <= rsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d; cur_q <= cur_d; lch_q <= lch_d; pos_q <= pos_d;
    now_q <= now_d; fid_q <= fid_d;
    rk_q <= rk_d; rid_q <= rid_d; rw_q <= rw_d; rc_q <= rc_d; rl_q <= rl_d;
  end

  assign res_o.valid = rv_q;
  assign res_o.kind = rk_q;
  assign res_o.timer_id = rid_q;
  assign res_o.wait_ms = rw_q;
  assign res_o.pending_count = rc_q;
  assign res_o.last = rl_q;

  `ASSERT_CLK(a_count_le_depth, count_q <= DepthC, "heap count above depth")
  `ASSERT_CLK(a_ready_idle, cmd_i.ready |-> state_q == SIdle, "ready while busy")
  `ASSERT_CLK(a_hold_res, rv_q && !res_o.ready |=> rv_q && $stable(rid_q), "result dropped")
  `ASSERT_NEVER(a_ready_with_res, cmd_i.ready && rv_q, "input open while result waits")
endmodule
`default_nettype wire

[verif/tmh_scoreboard.sv]
//------------------------------------------------------------------------------
// tmh_scoreboard
// Timer heap predictor and queue of expected result items.
//------------------------------------------------------------------------------
package tmh_scoreboard_pkg;
  import tmh_pkg::*;

  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic [OutIdW-1:0]       timer_id;
    logic signed [WaitW-1:0] wait_ms;
    logic [CountW-1:0]       pending_count;
    logic                    last;
  } tmh_result_t;

  typedef struct packed {
    logic [DefTimeBits-1:0] expiry;
    logic [DefIdBits-1:0]   id;
  } timer_entry_t;

  class tmh_scoreboard;
    timer_entry_t          timers[DefDepth];
    int unsigned           timer_count;
    logic [DefIdBits-1:0]  id_counter;
    tmh_result_t           pending_results[$];
    int unsigned           error_count;

    function new();
      timer_count = 0;
      id_counter  = '0;
      error_count = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      timer_entry_t t;
      t = timers[a];
      timers[a] = timers[b];
      timers[b] = t;
    endfunction

    function void push_result(logic [KindW-1:0] k, logic [OutIdW-1:0] id,
                              logic signed [WaitW-1:0] w, logic l);
      tmh_result_t r;
      r.kind = k;
      r.timer_id = id;
      r.wait_ms = w;
      r.pending_count = timer_count[CountW-1:0];
      r.last = l;
      pending_results.insert(pending_results.size(), r);
    endfunction

    // Note one accepted command item and queue the results it causes.
    function void note_command(logic [CmdW-1:0] cmd, logic [InTimeW-1:0] expire_t,
                               logic [InTimeW-1:0] now_t);
      int unsigned pos, up, lc, rc, best, fired;
      logic [DefIdBits-1:0] id;
      if (cmd == CmdAdd) begin
        if (timer_count >= DefDepth) begin
          push_result(KindReject, '0, '0, 1'b1);
          return;
        end
        timers[timer_count] = '{expiry: expire_t, id: id_counter};
        pos = timer_count;
        timer_count++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (timers[pos].expiry >= timers[up].expiry) break;
          swap_slots(pos, up);
          pos = up;
        end
        push_result(KindAdded, id_counter, '0, 1'b1);
        id_counter++;
      end else if (cmd == CmdService) begin
        fired = 0;
        while (timer_count > 0 && timers[0].expiry <= now_t) begin
          id = timers[0].id;
          timer_count--;
          if (timer_count > 0) begin
            timers[0] = timers[timer_count];
            pos = 0;
            while (pos < timer_count) begin
              lc = 2 * pos + 1;
              rc = 2 * pos + 2;
              best = pos;
              if (lc < timer_count && timers[lc].expiry < timers[best].expiry) best = lc;
              if (rc < timer_count && timers[rc].expiry < timers[best].expiry) best = rc;
              if (best == pos) break;
              swap_slots(pos, best);
              pos = best;
            end
          end
          push_result(KindFired, id, '0, 1'b0);
          fired++;
        end
        // flag the final pop of this service
        if (fired > 0) pending_results[$].last = 1'b1;
      end else if (cmd == CmdQuery) begin
        if (timer_count == 0)
          push_result(KindWait, '0, -49'sd1, 1'b1);
        else if (timers[0].expiry > now_t)
          push_result(KindWait, '0, {1'b0, timers[0].expiry - now_t}, 1'b1);
        else
          push_result(KindWait, '0, '0, 1'b1);
      end
    endfunction

    task automatic report(string what);
      $display("mismatch: %s", what);
      error_count++;
    endtask

    // Compare one accepted result against the oldest expectation.
    task automatic check_result(tmh_result_t got);
      tmh_result_t exp_r;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind=%0d id=%0d", got.kind, got.timer_id));
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.kind != exp_r.kind)
        report($sformatf("kind %0d, want %0d", got.kind, exp_r.kind));
      if (got.timer_id != exp_r.timer_id)
        report($sformatf("timer_id %0d, want %0d", got.timer_id, exp_r.timer_id));
      if (got.wait_ms != exp_r.wait_ms)
        report($sformatf("wait_ms %0d, want %0d", got.wait_ms, exp_r.wait_ms));
      if (got.pending_count != exp_r.pending_count)
        report($sformatf("pending_count %0d, want %0d", got.pending_count,
                         exp_r.pending_count));
      if (got.last != exp_r.last)
        report($sformatf("last %0d, want %0d", got.last, exp_r.last));
    endtask
  endclass
endpackage

[verif/testbench.sv]
//------------------------------------------------------------------------------
// testbench
// Drives add, service, query and unused commands into the timer heap core, predicts
// every result item with a software heap and checks each one in order.
//------------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tmh_pkg::*;
  import tmh_scoreboard_pkg::*;

  logic clk_i;
  logic rst_ni;

  tmh_cmd_if cmd_ch ();
  tmh_res_if res_ch ();

  timer_min_heap_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .res_o  (res_ch)
  );

  tmh_scoreboard timer_model;

  // Idle percentages for sender and receiver; changed between phases.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // Long receiver hold-off, counted down in the receiver process.
  int unsigned recv_hold_cycles;
  bit          stim_done;

  // Slowly advancing clock that random commands build on.
  logic [InTimeW-1:0] wall_ms;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [InTimeW-1:0] rand_time();
    return InTimeW'({$urandom, $urandom});
  endfunction

  // Send one command item: change at the falling edge, hold until taken.
  // Valid stays high after the item is taken; the next send or drain
  // replaces it within the same falling edge.
  task automatic send_command(logic [CmdW-1:0] cmd, logic [InTimeW-1:0] expire_t,
                              logic [InTimeW-1:0] now_t);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.cmd         <= cmd;
    cmd_ch.expire_time <= expire_t;
    cmd_ch.now_time    <= now_t;
    do @(posedge clk_i); while (!cmd_ch.ready);
    timer_model.note_command(cmd, expire_t, now_t);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected result item has come back.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (timer_model.pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Random command, mostly near the wall clock so timers actually fire.
  task automatic send_random();
    int unsigned sel;
    logic [InTimeW-1:0] t;
    sel = $urandom_range(99);
    wall_ms = wall_ms + InTimeW'($urandom_range(40));
    if (sel < 45) begin
      if ($urandom_range(19) == 0)
        t = rand_time();
      else
        t = wall_ms + InTimeW'($urandom_range(100));
      send_command(CmdAdd, t, rand_time());
    end else if (sel < 75) begin
      send_command(CmdService, rand_time(), wall_ms);
    end else if (sel < 95) begin
      send_command(CmdQuery, rand_time(),
                   ($urandom_range(9) == 0) ? rand_time() : wall_ms);
    end else begin
      send_command(CmdUnused, rand_time(), rand_time());
    end
  endtask

  // Receiver: ready toggles at the falling edge, results sampled at the rising.
  initial begin
    tmh_result_t got;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_hold_cycles != 0) begin
        recv_hold_cycles--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) begin
        got.kind          = res_ch.kind;
        got.timer_id      = res_ch.timer_id;
        got.wait_ms       = res_ch.wait_ms;
        got.pending_count = res_ch.pending_count;
        got.last          = res_ch.last;
        timer_model.check_result(got);
      end
    end
  end

  // Stimulus.
  initial begin
    timer_model      = new();
    stim_done        = 1'b0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    recv_hold_cycles = 0;
    wall_ms          = 48'd1000;
    cmd_ch.valid       = 1'b0;
    cmd_ch.cmd         = CmdAdd;
    cmd_ch.expire_time = '0;
    cmd_ch.now_time    = '0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty queries and services, unused code, extremes, ties.
    send_command(CmdQuery, '0, '0);
    send_command(CmdService, '1, '1);
    send_command(CmdUnused, '1, '1);
    send_command(CmdAdd, '1, '0);
    send_command(CmdAdd, '0, '1);
    send_command(CmdAdd, 48'd500, '0);
    send_command(CmdAdd, 48'd500, '0);
    send_command(CmdAdd, 48'd500, '0);
    send_command(CmdQuery, '0, '0);
    send_command(CmdQuery, '0, 48'd499);
    send_command(CmdQuery, '0, 48'hAAAA_AAAA_AAAA);
    send_command(CmdService, '0, 48'd0);
    send_command(CmdService, '0, 48'd499);
    send_command(CmdService, '0, 48'd500);
    send_command(CmdQuery, '0, 48'h5555_5555_5555);
    // Fill the heap past capacity so adds get rejected.
    for (int i = 0; i < DefDepth + 2; i++)
      send_command(CmdAdd, 48'd2000 + InTimeW'($urandom_range(30)), '0);
    send_command(CmdService, '0, '1);
    send_command(CmdQuery, '0, '0);
    drain();

    // Random part in three idle regimes.
    send_idle_pct = 13;
    recv_idle_pct = 77;
    for (int i = 0; i < 30; i++) send_random();
    // Long receiver stall while the sender keeps going.
    recv_hold_cycles = 400;
    for (int i = 0; i < 10; i++) send_random();
    send_idle_pct = 77;
    recv_idle_pct = 13;
    for (int i = 0; i < 30; i++) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 30; i++) send_random();

    drain();
    repeat (50) @(negedge clk_i);
    if (timer_model.error_count == 0 && timer_model.pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end
endmodule

[sim.f]
+incdir+hdl
hdl/tmh_pkg.sv
hdl/tmh_cmd_if.sv
hdl/tmh_heap_ram.sv
hdl/timer_min_heap_core.sv
verif/tmh_scoreboard.sv
verif/testbench.sv
